// File: rtl/k_way_sorted_merge_assert.svh
// ----------------------------------------------------------------------------
// k_way_sorted_merge_assert.svh
// Assertion macros shared by the merge checker.
// ----------------------------------------------------------------------------
`ifndef K_WAY_SORTED_MERGE_ASSERT_SVH
`define K_WAY_SORTED_MERGE_ASSERT_SVH

// same-cycle implication
`define KWSM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kwsm assertion failed");

// next-cycle implication
`define KWSM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kwsm assertion failed");

`endif

// File: rtl/kwsm_pkg.sv
// ----------------------------------------------------------------------------
// kwsm_pkg
// Types and constants for the k-way sorted merge.
// ----------------------------------------------------------------------------
package kwsm_pkg;

    localparam int LANE_W        = 3;   // lane field width
    localparam int VALUE_W       = 32;  // element width
    localparam int MAX_LANES     = 8;   // lanes reachable by the lane field
    localparam int LANES_DEFAULT = 8;
    localparam int CNT_W         = 4;   // lanes_in_use width
    localparam int APB_AW        = 3;
    localparam int APB_DW        = 32;

    localparam logic [CNT_W-1:0]  LANES_IN_USE_RST  = 4'd8;
    localparam logic [APB_AW-1:0] ADDR_LANES_IN_USE = 3'd0;

    typedef struct packed {
        logic [LANE_W-1:0]         lane;
        logic signed [VALUE_W-1:0] value;
        logic                      has_value;
        logic                      lane_ends;
    } kwsm_in_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] merged_value;
        logic [LANE_W-1:0]         from_lane;
        logic                      is_end;
    } kwsm_out_t;

    // result of the minimum search
    typedef struct packed {
        logic                      found;
        logic [LANE_W-1:0]         idx;
        logic signed [VALUE_W-1:0] value;
    } kwsm_pick_t;

endpackage

// File: rtl/kwsm_in_stage.sv
// ----------------------------------------------------------------------------
// kwsm_in_stage
// Input register with a one-entry skid buffer; stall comes from a flop.
// ----------------------------------------------------------------------------
module kwsm_in_stage
    import kwsm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  kwsm_in_t in_data,
    input  logic     adv,
    output logic     item_valid,
    output kwsm_in_t item
);

    logic     item_valid_reg, item_valid_next;
    logic     skid_full_reg, skid_full_next;
    kwsm_in_t item_reg, item_next;
    kwsm_in_t skid_reg, skid_next;
    logic     accept;

    assign in_stall   = skid_full_reg;
    assign accept     = in_valid && !skid_full_reg;
    assign item_valid = item_valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        skid_full_next  = skid_full_reg;
        item_next       = item_reg;
        skid_next       = skid_reg;
        if (adv)
        begin
            if (skid_full_reg)
            begin
                item_next       = skid_reg;
                item_valid_next = 1'b1;
                skid_full_next  = 1'b0;
            end
            else
            begin
                item_next       = in_data;
                item_valid_next = accept;
            end
        end
        else if (accept)
        begin
            if (item_valid_reg)
            begin
                skid_next      = in_data;
                skid_full_next = 1'b1;
            end
            else
            begin
                item_next       = in_data;
                item_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            skid_full_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            skid_full_reg  <= skid_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        skid_reg <= skid_next;
    end

endmodule

// File: rtl/kwsm_min_tree.sv
// ----------------------------------------------------------------------------
// kwsm_min_tree
// Balanced comparator tree: smallest valid head, ties to the lower lane.
// ----------------------------------------------------------------------------
module kwsm_min_tree
    import kwsm_pkg::*;
#(
    parameter int ACT = MAX_LANES
)
(
    input  logic [ACT-1:0]            vld,
    input  logic signed [VALUE_W-1:0] vals [ACT],
    output kwsm_pick_t                pick
);

    localparam int P = (ACT <= 2) ? 2 : ((ACT <= 4) ? 4 : 8);

    logic [P-1:0]              leaf_vld;
    logic signed [VALUE_W-1:0] leaf_val [P];
    logic                      node_vld [2*P];
    logic signed [VALUE_W-1:0] node_val [2*P];
    logic [LANE_W-1:0]         node_idx [2*P];

    assign leaf_vld = P'(vld);

    for (genvar k = 0; k < P; k++)
    begin : g_leaf
        if (k < ACT)
        begin : g_real
            assign leaf_val[k] = vals[k];
        end
        else
        begin : g_pad
            assign leaf_val[k] = '0;
        end
    end

    always_comb
    begin
        node_vld[0] = 1'b0;
        node_val[0] = '0;
        node_idx[0] = '0;
        for (int k = 0; k < P; k++)
        begin
            node_vld[P+k] = leaf_vld[k];
            node_val[P+k] = leaf_val[k];
            node_idx[P+k] = LANE_W'(k);
        end
        // right child wins only when strictly smaller
        for (int k = P - 1; k >= 1; k--)
        begin
            if (node_vld[2*k+1] && (!node_vld[2*k] || (node_val[2*k+1] < node_val[2*k])))
            begin
                node_vld[k] = 1'b1;
                node_val[k] = node_val[2*k+1];
                node_idx[k] = node_idx[2*k+1];
            end
            else
            begin
                node_vld[k] = node_vld[2*k];
                node_val[k] = node_val[2*k];
                node_idx[k] = node_idx[2*k];
            end
        end
        pick.found = node_vld[1];
        pick.idx   = node_idx[1];
        pick.value = node_val[1];
    end

endmodule

// File: rtl/k_way_sorted_merge.sv
// ----------------------------------------------------------------------------
// k_way_sorted_merge
// Pipeline: a transaction is registered in the input stage, passes once through
//   the head update and comparator tree, and its result is registered at the output.
// Throughput: one transaction per cycle while the output is not stalled, set by the
//   single pass through the head update and the comparator tree between item register and output.
// Reset: rst_n async low; heads empty, no lane ended, end not sent,
//   lanes_in_use = 8. Head values hold no reset.
// ----------------------------------------------------------------------------
module k_way_sorted_merge
    import kwsm_pkg::*;
#(
    parameter int LANES = LANES_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    // APB register port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    // input stream
    input  logic              in_valid,
    output logic              in_stall,
    input  kwsm_in_t          in_data,
    // merged stream
    output logic              out_valid,
    input  logic              out_stall,
    output kwsm_out_t         out_data
);

    // Only the first eight lanes can be addressed by the 3-bit lane field,
    // so storage is sized to the smaller of LANES and that limit.
    localparam int ACT = (LANES < MAX_LANES) ? LANES : MAX_LANES;

    // ------------------------------------------------------------------
    // Configuration: lanes_in_use at byte address 0
    // ------------------------------------------------------------------
    logic [CNT_W-1:0] lanes_reg;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_LANES_IN_USE);
    assign prdata = (paddr == ADDR_LANES_IN_USE) ? APB_DW'(lanes_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            lanes_reg <= LANES_IN_USE_RST;
        else if (cfg_wr)
            lanes_reg <= pwdata[CNT_W-1:0];
    end

    // output register state, declared here since the input side reads it
    logic      out_valid_reg, out_valid_next;
    kwsm_out_t out_data_reg, out_data_next;

    // ------------------------------------------------------------------
    // Input register. The pipe advances whenever the output register is
    // empty or being drained this cycle.
    // ------------------------------------------------------------------
    logic     adv;
    logic     item_valid;
    kwsm_in_t item;

    assign adv = !out_valid_reg || !out_stall;

    kwsm_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .adv        (adv),
        .item_valid (item_valid),
        .item       (item)
    );

    // ------------------------------------------------------------------
    // Lane state
    // ------------------------------------------------------------------
    logic signed [VALUE_W-1:0] head_value_reg [ACT];
    logic [ACT-1:0]            head_valid_reg, head_valid_next;
    logic [ACT-1:0]            finished_reg, finished_next;
    logic                      end_sent_reg, end_sent_next;

    // ------------------------------------------------------------------
    // Single pass: apply the transaction to its lane, then check readiness
    // and pick the smallest head from the updated view.
    // ------------------------------------------------------------------
    logic [CNT_W-1:0]          n_eff;
    logic [ACT-1:0]            in_use;
    logic [ACT-1:0]            load;
    logic [ACT-1:0]            hv_upd;
    logic [ACT-1:0]            fin_upd;
    logic signed [VALUE_W-1:0] cand_val [ACT];
    kwsm_pick_t                pick;
    logic                      ready;
    logic                      emit;
    logic                      emit_end;
    logic                      proc;

    // register values above the lane count saturate
    assign n_eff = (lanes_reg > CNT_W'(ACT)) ? CNT_W'(ACT) : lanes_reg;
    assign proc  = adv && item_valid;

    always_comb
    begin
        for (int i = 0; i < ACT; i++)
        begin
            in_use[i]   = CNT_W'(i) < n_eff;
            load[i]     = item_valid && in_use[i] && (item.lane == LANE_W'(i))
                          && item.has_value && !head_valid_reg[i] && !finished_reg[i];
            hv_upd[i]   = head_valid_reg[i] || load[i];
            // end mark applies even when the value was dropped
            fin_upd[i]  = finished_reg[i] || (item_valid && in_use[i]
                          && (item.lane == LANE_W'(i)) && item.lane_ends);
            cand_val[i] = load[i] ? item.value : head_value_reg[i];
        end
        // lanes out of use count as ended
        ready = &(hv_upd | fin_upd | ~in_use);
    end

    kwsm_min_tree #(
        .ACT (ACT)
    ) u_min_tree (
        .vld  (hv_upd & in_use),
        .vals (cand_val),
        .pick (pick)
    );

    assign emit     = ready && pick.found;
    assign emit_end = ready && !pick.found && !end_sent_reg;

    always_comb
    begin
        head_valid_next = head_valid_reg;
        finished_next   = finished_reg;
        end_sent_next   = end_sent_reg;
        if (proc)
        begin
            for (int i = 0; i < ACT; i++)
                head_valid_next[i] = hv_upd[i] && !(emit && (pick.idx == LANE_W'(i)));
            finished_next = fin_upd;
            end_sent_next = end_sent_reg || emit_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= '0;
            finished_reg   <= '0;
            end_sent_reg   <= 1'b0;
        end
        else
        begin
            head_valid_reg <= head_valid_next;
            finished_reg   <= finished_next;
            end_sent_reg   <= end_sent_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ACT; i++)
            if (proc && load[i])
                head_value_reg[i] <= item.value;
    end

    // ------------------------------------------------------------------
    // Output register. Holds while stalled; end result carries zeros.
    // ------------------------------------------------------------------
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (adv)
        begin
            out_valid_next             = proc && (emit || emit_end);
            out_data_next.merged_value = emit ? pick.value : '0;
            out_data_next.from_lane    = emit ? pick.idx : '0;
            out_data_next.is_end       = emit_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: rtl/kwsm_checker.sv
// ----------------------------------------------------------------------------
// kwsm_checker
// Port-level checks for the merge, bound to the top level.
// ----------------------------------------------------------------------------
`include "k_way_sorted_merge_assert.svh"

module kwsm_checker
    import kwsm_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              psel,
    input logic              penable,
    input logic              pwrite,
    input logic [APB_AW-1:0] paddr,
    input logic [APB_DW-1:0] pwdata,
    input logic [APB_DW-1:0] prdata,
    input logic              pready,
    input logic              in_valid,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input kwsm_out_t         out_data
);

    logic end_seen_reg;
    logic end_xfer;
    logic cfg_xfer;

    assign end_xfer = out_valid && !out_stall && out_data.is_end;
    assign cfg_xfer = psel && penable && pwrite && pready && (paddr == ADDR_LANES_IN_USE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            end_seen_reg <= 1'b0;
        else if (end_xfer)
            end_seen_reg <= 1'b1;
    end

    // stalled result holds
    `KWSM_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))

    // only one end transaction per reset
    `KWSM_ASSERT_IMP(a_single_end, clk, rst_n, end_xfer, !end_seen_reg)

    // input stalls only after a transaction went in
    `KWSM_ASSERT_IMP(a_stall_cause, clk, rst_n, $rose(in_stall), $past(in_valid && !in_stall))

    // register write visible on readback
    `KWSM_ASSERT_IMP(a_cfg_rdback, clk, rst_n, cfg_xfer ##1 (paddr == ADDR_LANES_IN_USE), prdata[CNT_W-1:0] == $past(pwdata[CNT_W-1:0]))

endmodule

bind k_way_sorted_merge kwsm_checker u_kwsm_checker (.*);

// File: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for k_way_sorted_merge. Streams ascending values into
// the lanes, keeping empty lanes refilled so the merge keeps firing, and
// mixes in ticks, stray values and items for unused lanes. A scoreboard
// mirrors the head registers and predicts each merged transaction.
// ----------------------------------------------------------------------------
module tb;
    import kwsm_pkg::*;

    localparam int NUM_LANES = LANES_DEFAULT;
    localparam int HOLD_CYCLES = 120;     // receiver hold-off, long enough to back up
    localparam int SETTLE = 8;            // output register plus skid slots, with margin
    localparam int CYCLE_LIMIT = 400000;
    localparam int REPORT_MAX = 10;
    localparam int RANDOM_PICK = 15;      // percent of items that are noise
    localparam int IDLE_PCT = 37;

    // ------------------------------------------------------------------------
    // Scoreboard: shadow copy of the heads, end flags and lane count. Each
    // accepted transaction updates the shadow and may queue one merged
    // result; each result seen on the output is matched against the oldest.
    // ------------------------------------------------------------------------
    class merge_scoreboard;
        logic [CNT_W-1:0]          lanes_cfg;
        logic signed [VALUE_W-1:0] head_val [MAX_LANES];
        bit                        head_vld [MAX_LANES];
        bit                        ended    [MAX_LANES];
        bit                        end_done;
        kwsm_out_t                 merged_ahead [$];
        int                        failures;

        function new();
            lanes_cfg = LANES_IN_USE_RST;
            foreach (head_vld[i])
            begin
                head_vld[i] = 0;
                ended[i] = 0;
                head_val[i] = '0;
            end
            end_done = 0;
            failures = 0;
        endfunction

        // lanes at or above this count behave as ended
        function int active();
            int n;
            n = lanes_cfg;
            if (n > NUM_LANES)
                n = NUM_LANES;
            if (n > MAX_LANES)
                n = MAX_LANES;
            return n;
        endfunction

        function bit lane_open(int l);
            return !head_vld[l] && !ended[l];
        endfunction

        function bit all_done();
            for (int i = 0; i < active(); i++)
                if (!ended[i] || head_vld[i])
                    return 0;
            return 1;
        endfunction

        function int pending();
            return merged_ahead.size();
        endfunction

        function void flag(string what);
            failures++;
            if (failures <= REPORT_MAX)
                $display("[%0t] ERROR: %s", $realtime, what);
        endfunction

        function void accept_item(kwsm_in_t t);
            int n;
            bit ready;
            bit found;
            int best;
            kwsm_out_t r;
            n = active();
            ready = 1;
            found = 0;
            best = 0;
            if (t.lane < n)
            begin
                // value is loaded before the end mark takes effect
                if (t.has_value && !head_vld[t.lane] && !ended[t.lane])
                begin
                    head_val[t.lane] = t.value;
                    head_vld[t.lane] = 1;
                end
                if (t.lane_ends)
                    ended[t.lane] = 1;
            end
            for (int i = 0; i < n; i++)
                if (!head_vld[i] && !ended[i])
                    ready = 0;
            if (!ready)
                return;
            // strict less-than keeps the lowest lane on ties
            for (int i = 0; i < n; i++)
                if (head_vld[i] && (!found || head_val[i] < head_val[best]))
                begin
                    best = i;
                    found = 1;
                end
            if (found)
            begin
                r.merged_value = head_val[best];
                r.from_lane = best[LANE_W-1:0];
                r.is_end = 1'b0;
                head_vld[best] = 0;
                merged_ahead.push_back(r);
            end
            else if (!end_done)
            begin
                end_done = 1;
                r.merged_value = '0;
                r.from_lane = '0;
                r.is_end = 1'b1;
                merged_ahead.push_back(r);
            end
        endfunction

        function void check_merged(kwsm_out_t got);
            kwsm_out_t exp;
            if (merged_ahead.size() == 0)
            begin
                flag($sformatf("unexpected result value=%0d lane=%0d end=%0b",
                               got.merged_value, got.from_lane, got.is_end));
                return;
            end
            exp = merged_ahead.pop_front();
            if (got.merged_value !== exp.merged_value || got.from_lane !== exp.from_lane ||
                got.is_end !== exp.is_end)
                flag($sformatf("result mismatch exp value=%0d lane=%0d end=%0b, got value=%0d lane=%0d end=%0b",
                               exp.merged_value, exp.from_lane, exp.is_end,
                               got.merged_value, got.from_lane, got.is_end));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    logic              in_valid;
    logic              in_stall;
    kwsm_in_t          in_data;
    logic              out_valid;
    logic              out_stall;
    kwsm_out_t         out_data;

    k_way_sorted_merge #(.LANES(NUM_LANES)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always #2 clk = ~clk;

    merge_scoreboard sb = new();

    // Shared between sender and receiver: calm turns off random idling on
    // both sides, hold_req asks the receiver for one long hold-off.
    bit  calm = 0;
    bit  hold_req = 0;
    int  cycle_count = 0;

    // last value sent per lane, so each lane stays ascending
    longint lane_last [MAX_LANES];

    // ------------------------------------------------------------------------
    // Receiver: checks every accepted merged transaction, then picks the
    // stall level for the next cycle. The hold-off is counted here.
    // ------------------------------------------------------------------------
    initial
    begin
        int hold_left;
        hold_left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
                sb.check_merged(out_data);
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (hold_req)
            begin
                hold_req = 0;
                hold_left = HOLD_CYCLES;
                out_stall <= 1'b1;
            end
            else
                out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // Watchdog: a hung handshake ends the run here.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("k_way_sorted_merge verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------
    function automatic kwsm_in_t mk(int l, logic signed [VALUE_W-1:0] v, bit hv, bit le);
        kwsm_in_t t;
        t.lane = l[LANE_W-1:0];
        t.value = v;
        t.has_value = hv;
        t.lane_ends = le;
        return t;
    endfunction

    // Ascending per lane; a zero step gives ties, overflow restarts the
    // lane at a random point so the upper bits keep moving.
    function automatic logic signed [VALUE_W-1:0] next_value(int l);
        longint step;
        longint nv;
        step = longint'($urandom_range(0, 1 << $urandom_range(0, 30)));
        nv = lane_last[l] + step;
        if (nv > 64'sd2147483647)
            nv = longint'(int'($urandom));
        lane_last[l] = nv;
        return nv[VALUE_W-1:0];
    endfunction

    // Mostly refills an empty lane (what the merge asks for next); the rest
    // is noise: ticks, values for full or unused lanes. Only closing phases
    // send end marks.
    function automatic kwsm_in_t pick_item(bit closing);
        int empties [$];
        int l;
        for (int i = 0; i < sb.active(); i++)
            if (sb.lane_open(i))
                empties.push_back(i);
        if (empties.size() == 0 || $urandom_range(0, 99) < RANDOM_PICK)
            return mk($urandom_range(0, MAX_LANES - 1), $urandom,
                      1'($urandom_range(0, 1)), 1'b0);
        l = empties[$urandom_range(0, empties.size() - 1)];
        if (closing && $urandom_range(0, 3) == 0)
            return mk(l, next_value(l), 1'($urandom_range(0, 1)), 1'b1);
        return mk(l, next_value(l), 1'b1, 1'b0);
    endfunction

    // Offer one transaction and hold it until accepted, then maybe idle.
    task automatic send_item(kwsm_in_t t);
        in_valid <= 1'b1;
        in_data <= t;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        sb.accept_item(t);
        if (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < IDLE_PCT);
        end
    endtask

    // Stop offering and let every predicted result drain, plus the time an
    // item with no result may still spend in the pipe.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // APB write of lanes_in_use followed by a read-back.
    task automatic set_lane_count(logic [APB_DW-1:0] word);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_LANES_IN_USE;
        pwdata <= word;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        sb.lanes_cfg = word[CNT_W-1:0];
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        if (prdata[CNT_W-1:0] !== word[CNT_W-1:0])
            sb.flag($sformatf("lanes_in_use read back %0h, wrote %0h",
                              prdata[CNT_W-1:0], word[CNT_W-1:0]));
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic run_items(int count, int hold_at);
        for (int k = 0; k < count; k++)
        begin
            if (k == hold_at)
                hold_req = 1;
            send_item(pick_item(1'b0));
        end
    endtask

    // Keep feeding, with end marks, until every lane in use is closed out.
    task automatic close_lanes();
        int guard;
        guard = 0;
        while (!sb.all_done() && guard < 400)
        begin
            send_item(pick_item(1'b1));
            guard++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        foreach (lane_last[i])
            lane_last[i] = -64'sd2147483648;
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        in_valid <= 1'b0;
        in_data <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, on the reset lane count of eight.
        send_item(mk(0, 32'sh7FFF_FFFF, 1'b1, 1'b0));   // max value
        send_item(mk(0, 32'sd5, 1'b1, 1'b0));           // lane already full: dropped
        send_item(mk(1, 32'sd0, 1'b0, 1'b0));           // tick only
        send_item(mk(1, 32'sh8000_0000, 1'b1, 1'b0));   // min value
        send_item(mk(2, -32'sd1, 1'b1, 1'b0));
        send_item(mk(3, 32'sd0, 1'b1, 1'b0));           // three-way tie at zero
        send_item(mk(4, 32'sd0, 1'b1, 1'b0));
        send_item(mk(5, 32'sh5555_5555, 1'b1, 1'b0));
        send_item(mk(6, 32'shAAAA_AAAA, 1'b1, 1'b0));
        send_item(mk(7, 32'sd0, 1'b1, 1'b0));           // all full: first merge
        send_item(mk(1, 32'sh8000_0000, 1'b1, 1'b1));   // value and end together
        send_item(mk(1, 32'sd3, 1'b1, 1'b0));           // ended lane: dropped
        send_item(mk(5, 32'sd0, 1'b0, 1'b1));           // end mark with head held
        send_item(mk(2, -32'sd7, 1'b1, 1'b0));
        send_item(mk(3, 32'sd0, 1'b1, 1'b0));           // tie with lane 4 again

        // Random phases. Each count change waits for the block to go idle.
        wait_drained();
        set_lane_count(32'd15);          // above the limit, saturates to eight
        run_items(120, -1);
        wait_drained();
        set_lane_count(32'd1);
        run_items(100, -1);
        wait_drained();
        set_lane_count(32'd8);
        calm = 1;                        // no idling on either side here
        run_items(120, -1);
        calm = 0;
        wait_drained();
        set_lane_count(($urandom & ~32'hF) | 32'd3);   // junk in the upper bits
        run_items(110, 40);
        wait_drained();
        set_lane_count(32'd2);
        run_items(80, -1);
        wait_drained();
        set_lane_count(32'd8);
        run_items(150, 60);
        wait_drained();
        set_lane_count(32'd5);
        run_items(90, -1);
        wait_drained();
        set_lane_count(32'd7);
        run_items(60, -1);

        // Close lanes 0..5; the last close gives the single end result.
        wait_drained();
        set_lane_count(32'd6);
        run_items(30, -1);
        close_lanes();

        // Lanes 6 and 7 reopen and merge, but no second end result.
        wait_drained();
        set_lane_count(32'd8);
        run_items(40, -1);
        close_lanes();

        // No lanes in use after the end: nothing comes out.
        wait_drained();
        set_lane_count(32'd0);
        run_items(20, -1);

        wait_drained();
        if (sb.pending() > 0)
            sb.flag($sformatf("%0d results never arrived", sb.pending()));
        if (sb.failures == 0)
            $display("k_way_sorted_merge verification clean");
        else
            $display("k_way_sorted_merge verification failed");
        $finish;
    end

endmodule
